/* rtl/ptd_pkg.sv */
package ptd_pkg;

  // Field widths
  localparam int PIN_W      = 11;
  localparam int HEIGHT_W   = 8;
  localparam int DIFF_W     = 9;
  localparam int PIN_EXT_W  = 17;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Default sizes
  localparam int PIN_COUNT_DEF = 2048;
  localparam int WINDOW_DEF    = 8;

  // Reset values
  localparam logic [HEIGHT_W-1:0] HISTORY_RESET   = 8'd210;
  localparam logic [HEIGHT_W-1:0] FLAT_TOL_RESET  = 8'd2;
  localparam logic [HEIGHT_W-1:0] TOUCH_THR_RESET = 8'd21;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THR = 2'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // capture input item, issue history read
    logic load_win;   // shift new command into window copy
    logic scan_en;    // fold one window byte into min/max
    logic finish;     // write history back, form flags
    logic out_load;   // move result into output register
    logic clr_we;     // write reset window at clear address
  } ptd_cmd_t;

endpackage

/* rtl/ptd_datapath.sv */
module ptd_datapath #(
  parameter int PIN_COUNT = ptd_pkg::PIN_COUNT_DEF,
  parameter int WINDOW    = ptd_pkg::WINDOW_DEF,
  parameter int ADDR_W    = 11,
  parameter int IDX_W     = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ptd_pkg::ptd_cmd_t                   cmd,
  input  logic [ADDR_W-1:0]                   clr_addr,
  input  logic [IDX_W-1:0]                    scan_idx,
  // pin_index, commanded_height, measured_height (lowest bits first)
  input  logic [ptd_pkg::IN_DATA_W-1:0]       in_data,
  input  logic                                cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptd_pkg::HEIGHT_W-1:0]        cfg_data,
  // height_difference, pin_steady, pin_touched (lowest bits first)
  output logic [ptd_pkg::OUT_DATA_W-1:0]      out_data
);

  localparam int HW   = ptd_pkg::HEIGHT_W;
  localparam int WORD = WINDOW * HW;

  // History memory, one window word per pin
  logic [WORD-1:0] mem [PIN_COUNT];
  logic [WORD-1:0] rd_data;
  logic [WORD-1:0] wr_word;

  logic [HW-1:0] flat_tol;
  logic [HW-1:0] touch_thr;

  logic [ptd_pkg::PIN_W-1:0]     pin_in;
  logic [ptd_pkg::PIN_EXT_W-1:0] pin_ext;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             pin_addr;
  logic                          range_ok;
  logic [HW-1:0]                 cmd_h;
  logic [HW-1:0]                 meas_h;

  logic [HW-1:0] win [WINDOW];
  logic [HW-1:0] lo;
  logic [HW-1:0] hi;
  logic [HW-1:0] cur;

  logic [ptd_pkg::DIFF_W-1:0] diff;
  logic [ptd_pkg::DIFF_W-1:0] neg_diff;
  logic [HW-1:0]              mag;
  logic [HW-1:0]              spread;
  logic                       steady_c;
  logic                       steady_r;
  logic                       touched_r;

  // Input unpacking and address forming
  assign pin_in  = in_data[ptd_pkg::PIN_W-1:0];
  assign pin_ext = ptd_pkg::PIN_EXT_W'(pin_in);
  assign rd_addr = pin_ext[ADDR_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_tol  <= ptd_pkg::FLAT_TOL_RESET;
      touch_thr <= ptd_pkg::TOUCH_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ptd_pkg::REG_FLAT_TOL:  flat_tol  <= cfg_data;
        ptd_pkg::REG_TOUCH_THR: touch_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture and history read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pin_addr <= rd_addr;
      range_ok <= pin_ext < ptd_pkg::PIN_EXT_W'(PIN_COUNT);
      cmd_h    <= in_data[ptd_pkg::PIN_W +: HW];
      meas_h   <= in_data[ptd_pkg::PIN_W + HW +: HW];
      rd_data  <= mem[rd_addr];
    end
  end

  // Pack window for write-back
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      wr_word[k*HW +: HW] = win[k];
    end
  end

  // History write: clearing pass or item write-back
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mem[clr_addr] <= {WINDOW{ptd_pkg::HISTORY_RESET}};
    end else if (cmd.finish && range_ok) begin
      mem[pin_addr] <= wr_word;
    end
  end

  // Window shift and min/max scan, one byte per cycle
  assign cur = win[scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.load_win) begin
      win[0] <= cmd_h;
      for (int k = 1; k < WINDOW; k++) begin
        win[k] <= rd_data[(k-1)*HW +: HW];
      end
      lo <= '1;
      hi <= '0;
    end else if (cmd.scan_en) begin
      if (cur < lo) lo <= cur;
      if (cur > hi) hi <= cur;
    end
  end

  // Difference, magnitude and flags
  assign diff     = {1'b0, cmd_h} - {1'b0, meas_h};
  assign neg_diff = '0 - diff;
  assign mag      = diff[ptd_pkg::DIFF_W-1] ? neg_diff[HW-1:0] : diff[HW-1:0];
  assign spread   = hi - lo;
  assign steady_c = range_ok && (spread <= flat_tol);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      steady_r  <= steady_c;
      touched_r <= steady_c && (mag > touch_thr);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {(ptd_pkg::OUT_DATA_W - ptd_pkg::DIFF_W - 2)'(0), touched_r, steady_r, diff};
    end
  end

endmodule

/* rtl/ptd_ctrl.sv */
module ptd_ctrl #(
  parameter int PIN_COUNT = ptd_pkg::PIN_COUNT_DEF,
  parameter int WINDOW    = ptd_pkg::WINDOW_DEF,
  parameter int ADDR_W    = 11,
  parameter int IDX_W     = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ptd_pkg::ptd_cmd_t cmd,
  output logic [ADDR_W-1:0] clr_addr,
  output logic [IDX_W-1:0]  scan_idx
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.accept   = in_ready && in_valid;
    cmd.clr_we   = (state == S_CLEAR);
    cmd.load_win = (state == S_LOAD);
    cmd.scan_en  = (state == S_SCAN);
    cmd.finish   = (state == S_WRITE);
    cmd.out_load = (state == S_DONE) && slot_free;
  end

  // Sequencer: state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE a consumed result is replaced by the new one below
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(PIN_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_LOAD;
        end
        S_LOAD: begin
          scan_idx <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == IDX_W'(WINDOW - 1)) state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pin_touch_detector.sv */
// Touch detector for an actuated pin array. Each input item names a pin and carries its
// commanded and measured height; one result item comes back per input with commanded minus
// measured height and the steady and touched flags. After an item is accepted its result is
// formed in steps: the pin's history word is read from the single history memory at the
// accepting edge, the LOAD state builds the shifted window, the min/max scan takes one window
// byte per cycle, the WRITE state writes the history back and forms the flags, and the DONE
// state loads the output register once it is free. Items are taken one at a time, the next
// only after the previous result is loaded; a result waiting in the output register does not
// hold off the next input, but that item's result waits until the register is free. After
// reset the history memory is cleared to 210 in every byte, one pin per cycle, and no item is
// accepted until every pin is cleared.
// Configuration writes are accepted at any time; pins at or beyond PIN_COUNT leave the
// history untouched and report not steady and not touched.
module pin_touch_detector #(
  parameter int PIN_COUNT = ptd_pkg::PIN_COUNT_DEF,
  parameter int WINDOW    = ptd_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pin_index[10:0], commanded_height[18:11], measured_height[26:19], zero fill
  input  logic [ptd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // height_difference[8:0], pin_steady[9], pin_touched[10], zero fill
  output logic [ptd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptd_pkg::HEIGHT_W-1:0]      cfg_data
);

  localparam int ADDR_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  ptd_pkg::ptd_cmd_t  cmd;
  logic [ADDR_W-1:0]  clr_addr;
  logic [IDX_W-1:0]   scan_idx;

  assign cfg_ready = 1'b1;

  ptd_ctrl #(
    .PIN_COUNT (PIN_COUNT),
    .WINDOW    (WINDOW),
    .ADDR_W    (ADDR_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .clr_addr  (clr_addr),
    .scan_idx  (scan_idx)
  );

  ptd_datapath #(
    .PIN_COUNT (PIN_COUNT),
    .WINDOW    (WINDOW),
    .ADDR_W    (ADDR_W),
    .IDX_W     (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .clr_addr  (clr_addr),
    .scan_idx  (scan_idx),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_axis_tdata)
  );

endmodule

/* tb/tb_pin_touch_detector.sv */
`timescale 1ns / 1ps

module tb_pin_touch_detector;
  import ptd_pkg::*;

  localparam int WIN_LEN = (WINDOW_DEF > 8) ? 8 : ((WINDOW_DEF < 1) ? 1 : WINDOW_DEF);
  localparam int SETTLE_CYCLES = WINDOW_DEF + 8;
  localparam int DRAIN_CYCLES = WINDOW_DEF + 20;
  localparam int CALM_TAIL = 40;
  localparam int RUN_LIMIT_NS = 3_000_000;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {OP_SAMPLE, OP_WRITE_REG} op_kind_e;

  typedef struct {
    op_kind_e              kind;
    logic [PIN_W-1:0]      pin;
    logic [HEIGHT_W-1:0]   cmd;
    logic [HEIGHT_W-1:0]   meas;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [HEIGHT_W-1:0]   reg_val;
  } pending_op_t;

  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic              steady;
    logic              touched;
  } pin_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [HEIGHT_W-1:0] cfg_data = '0;

  // Shadow of the block: command windows, newest first, and the two registers
  logic [HEIGHT_W-1:0] cmd_window [PIN_COUNT_DEF][WIN_LEN];
  logic [HEIGHT_W-1:0] tol_model;
  logic [HEIGHT_W-1:0] thr_model;

  pending_op_t pending_ops[$];
  pin_report_t report_queue[$];
  int fail_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_run = 0;

  pin_touch_detector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shift the command into the pin's window and work out difference and flags
  function automatic pin_report_t sense_pin(logic [PIN_W-1:0] pin, logic [HEIGHT_W-1:0] cmd,
                                            logic [HEIGHT_W-1:0] meas);
    pin_report_t rep;
    logic [HEIGHT_W-1:0] lo;
    logic [HEIGHT_W-1:0] hi;
    logic [HEIGHT_W-1:0] mag;
    rep.diff = {1'b0, cmd} - {1'b0, meas};
    mag = (cmd >= meas) ? cmd - meas : meas - cmd;
    rep.steady = 1'b0;
    rep.touched = 1'b0;
    if (int'(pin) < PIN_COUNT_DEF) begin
      for (int k = WIN_LEN - 1; k > 0; k--) cmd_window[pin][k] = cmd_window[pin][k-1];
      cmd_window[pin][0] = cmd;
      lo = 8'hFF;
      hi = 8'h00;
      for (int k = 0; k < WIN_LEN; k++) begin
        if (cmd_window[pin][k] > hi) hi = cmd_window[pin][k];
        if (cmd_window[pin][k] < lo) lo = cmd_window[pin][k];
      end
      rep.steady = ((hi - lo) <= tol_model);
      rep.touched = rep.steady && (mag > thr_model);
    end
    return rep;
  endfunction

  task automatic add_sample(logic [PIN_W-1:0] pin, logic [HEIGHT_W-1:0] cmd,
                            logic [HEIGHT_W-1:0] meas);
    pending_op_t op;
    op.kind = OP_SAMPLE;
    op.pin = pin;
    op.cmd = cmd;
    op.meas = meas;
    op.reg_idx = '0;
    op.reg_val = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [HEIGHT_W-1:0] val);
    pending_op_t op;
    op.kind = OP_WRITE_REG;
    op.pin = '0;
    op.cmd = '0;
    op.meas = '0;
    op.reg_idx = idx;
    op.reg_val = val;
    pending_ops.push_back(op);
  endtask

  // Mostly runs on a few pins with commands bunched around the tolerance and
  // differences around the threshold; the rest is noise on any pin
  task automatic add_random_items(int count, int tol, int thr);
    logic [PIN_W-1:0] pool [4];
    int made;
    int run_len;
    int base;
    int spread;
    int cmd;
    int meas;
    int delta;
    int pick;
    for (int i = 0; i < 4; i++) pool[i] = PIN_W'($urandom_range(0, 2047));
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 3);
        run_len = $urandom_range(1, 10);
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, (tol + 2 > 255) ? 255 : tol + 2);
        repeat (run_len) begin
          cmd = base + $urandom_range(0, spread);
          if (cmd > 255) cmd = 255;
          delta = $urandom_range(0, (thr + 4 > 255) ? 255 : thr + 4);
          meas = $urandom_range(0, 1) ? cmd + delta : cmd - delta;
          if (meas > 255) meas = 255;
          if (meas < 0) meas = 0;
          add_sample(pool[pick], HEIGHT_W'(cmd), HEIGHT_W'(meas));
          made++;
        end
      end else begin
        add_sample(PIN_W'($urandom_range(0, 2047)), HEIGHT_W'($urandom_range(0, 255)),
                   HEIGHT_W'($urandom_range(0, 255)));
        made++;
      end
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Item and register-write driver
  always @(posedge clk) begin : driver
    logic                 next_valid;
    logic [IN_DATA_W-1:0] next_data;
    logic                 next_cfg_valid;
    logic [CFG_IDX_W-1:0] next_idx;
    logic [HEIGHT_W-1:0]  next_val;
    pending_op_t          op;
    next_valid = s_axis_tvalid;
    next_data = s_axis_tdata;
    next_cfg_valid = cfg_valid;
    next_idx = cfg_index;
    next_val = cfg_data;
    if (rst) begin
      next_valid = 1'b0;
      next_cfg_valid = 1'b0;
      gap_left = 0;
      idle_run = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        report_queue.push_back(sense_pin(s_axis_tdata[PIN_W-1:0],
                                         s_axis_tdata[PIN_W +: HEIGHT_W],
                                         s_axis_tdata[PIN_W + HEIGHT_W +: HEIGHT_W]));
        next_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FLAT_TOL:  tol_model = cfg_data;
          REG_TOUCH_THR: thr_model = cfg_data;
          default: ;
        endcase
        next_cfg_valid = 1'b0;
      end
      // count quiet cycles before a register write is allowed
      if (report_queue.size() == 0 && !s_axis_tvalid) idle_run++;
      else idle_run = 0;
      if (!next_valid && !next_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops[0];
          if (op.kind == OP_SAMPLE) begin
            void'(pending_ops.pop_front());
            next_valid = 1'b1;
            next_data = '0;
            next_data[PIN_W-1:0] = op.pin;
            next_data[PIN_W +: HEIGHT_W] = op.cmd;
            next_data[PIN_W + HEIGHT_W +: HEIGHT_W] = op.meas;
            if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 4) == 0)
              gap_left = $urandom_range(1, 6);
          end else if (idle_run >= SETTLE_CYCLES) begin
            void'(pending_ops.pop_front());
            next_cfg_valid = 1'b1;
            next_idx = op.reg_idx;
            next_val = op.reg_val;
          end
        end
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata <= next_data;
    cfg_valid <= next_cfg_valid;
    cfg_index <= next_idx;
    cfg_data <= next_val;
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : monitor
    pin_report_t want;
    logic        next_ready;
    next_ready = m_axis_tready;
    if (rst) begin
      next_ready = 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_queue.size() == 0) begin
          $error("result item with no expectation pending: 0x%h", m_axis_tdata);
          fail_count++;
        end else begin
          want = report_queue.pop_front();
          if (m_axis_tdata[DIFF_W-1:0] !== want.diff) begin
            $error("height_difference: expected %0d, got %0d", $signed(want.diff),
                   $signed(m_axis_tdata[DIFF_W-1:0]));
            fail_count++;
          end
          if (m_axis_tdata[DIFF_W] !== want.steady) begin
            $error("pin_steady: expected %0d, got %0d", want.steady, m_axis_tdata[DIFF_W]);
            fail_count++;
          end
          if (m_axis_tdata[DIFF_W+1] !== want.touched) begin
            $error("pin_touched: expected %0d, got %0d", want.touched,
                   m_axis_tdata[DIFF_W+1]);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
    end
    m_axis_tready <= next_ready;
  end

  // Stimulus, reset and end of run
  initial begin
    for (int p = 0; p < PIN_COUNT_DEF; p++)
      for (int k = 0; k < WIN_LEN; k++) cmd_window[p][k] = HISTORY_RESET;
    tol_model = FLAT_TOL_RESET;
    thr_model = TOUCH_THR_RESET;

    // directed: reset settings, windows all at 210
    add_sample(11'd0, 8'd210, 8'd0);      // flat window, large difference
    add_sample(11'd0, 8'd210, 8'd189);    // difference equal to threshold
    add_sample(11'd0, 8'd210, 8'd188);    // one above threshold
    add_sample(11'd0, 8'd212, 8'd190);    // spread equal to tolerance
    add_sample(11'd0, 8'd213, 8'd255);    // spread one past tolerance
    add_sample(11'd2047, 8'd255, 8'd255);
    add_sample(11'd1, 8'd0, 8'd255);      // most negative difference
    add_sample(11'd1365, 8'd255, 8'd0);
    add_sample(11'd682, 8'd170, 8'd85);
    // window fills up with a new level on the eighth sample
    repeat (WIN_LEN) add_sample(11'd5, 8'd100, 8'd130);

    // writes past the register list must leave both registers alone
    add_write(REG_SPARE_A, 8'd255);
    add_write(REG_SPARE_B, 8'd255);
    add_sample(11'd3, 8'd210, 8'd232);
    add_sample(11'd3, 8'd212, 8'd210);

    // random phases across register settings, extremes included
    add_write(REG_FLAT_TOL, 8'd0);
    add_write(REG_TOUCH_THR, 8'd0);
    add_random_items(95, 0, 0);
    add_write(REG_FLAT_TOL, 8'd255);
    add_write(REG_TOUCH_THR, 8'd255);
    add_random_items(95, 255, 255);
    add_write(REG_TOUCH_THR, 8'd0);
    add_random_items(95, 255, 0);
    add_write(REG_FLAT_TOL, 8'd0);
    add_write(REG_TOUCH_THR, 8'd255);
    add_random_items(95, 0, 255);
    begin : random_setting
      int tol;
      int thr;
      tol = $urandom_range(0, 20);
      thr = $urandom_range(0, 255);
      add_write(REG_FLAT_TOL, HEIGHT_W'(tol));
      add_write(REG_TOUCH_THR, HEIGHT_W'(thr));
      add_random_items(95, tol, thr);
    end
    add_write(REG_FLAT_TOL, FLAT_TOL_RESET);
    add_write(REG_TOUCH_THR, TOUCH_THR_RESET);
    add_random_items(95, int'(FLAT_TOL_RESET), int'(TOUCH_THR_RESET));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_axis_tvalid || cfg_valid || report_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $error("run timed out with %0d results outstanding", report_queue.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
